// File: design/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/csr_adj_pkg.sv
package csr_adj_pkg;

  localparam int VERTEX_W         = 8;
  localparam int CNT_W            = 13;
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 4096;

  typedef enum logic [1:0] {
    REQ_ADD_EDGE  = 2'd0,
    REQ_DEL_EDGE  = 2'd1,
    REQ_DEL_VERT  = 2'd2,
    REQ_QUERY     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOOKUP, S_RS_B, S_RS_E, S_SCAN, S_DECIDE, S_APPEND, S_SHUP,
    S_INS, S_SHDN, S_ADJ, S_RV_ROW, S_RV_E, S_RV_SCAN, S_DONE
  } state_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [VERTEX_W-1:0]   source_vertex;
    logic [VERTEX_W-1:0]   target_vertex;
  } req_t;

  typedef struct packed {
    logic                  edge_found;
    status_t               status;
    logic [CNT_W-1:0]      removed_count;
    logic [CNT_W-1:0]      edge_total;
  } result_t;

endpackage

// File: design/csr_adjacency_edge_table.sv
// Channel   | Ports                    | Handshake
// ----------+--------------------------+-------------------------------------
// request   | start, busy, request     | taken when start high and busy low
// result    | done, result             | one-cycle strobe, cannot be held off
//
// One request at a time. Query: looks up the source row bounds and scans the row; remove edge
// also shifts down the entries above the edge and lowers the later row starts. Add edge appends
// rows up to the source, shifts entries up and raises the later row starts; remove vertex walks every row.
// All bounded by the single-port sweep of the neighbour store (one entry per cycle).
// Reset (rst, synchronous) empties the graph at once; no clearing pass.
// The receiver cannot stall; busy drops in the cycle the result strobe shows.
module csr_adjacency_edge_table #(
  parameter int MAX_VERTICES = csr_adj_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = csr_adj_pkg::DEF_MAX_EDGES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  csr_adj_pkg::req_t    request,
  output logic                 done,
  output csr_adj_pkg::result_t result
);
  import csr_adj_pkg::*;
`include "assert_macros.svh"

  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = $clog2(MAX_EDGES);
  localparam int RW = $clog2(MAX_VERTICES + 1);
  localparam int CW = $clog2(MAX_VERTICES + 2);

  // storage
  logic [VERTEX_W-1:0] nl_mem [0:MAX_EDGES-1];
  logic [EW-1:0]       rs_mem [0:MAX_VERTICES];

  logic [AW-1:0]       nl_raddr, nl_waddr;
  logic [VERTEX_W-1:0] nl_rdata, nl_wdata;
  logic                nl_we;
  logic [RW-1:0]       rs_raddr, rs_waddr;
  logic [EW-1:0]       rs_rdata, rs_wdata, rs_q;
  logic                rs_we, rs_zero;

  state_t              state, state_next;
  req_type_t           rtype, rtype_next;
  logic [VERTEX_W-1:0] src, src_next, dst, dst_next;
  logic                found, found_next;
  status_t             status, status_next;
  logic [EW-1:0]       removed, removed_next;
  logic [EW-1:0]       total, total_next;
  logic [CW-1:0]       row_count, row_count_next;
  logic [EW-1:0]       k, k_next, e, e_next, b, b_next, pos, pos_next;
  logic [EW-1:0]       gap, gap_next;
  logic [CW-1:0]       r, r_next;
  logic                pend, pend_next, inc, inc_next;
  logic                done_next;
  result_t             result_next;

  logic [EW-1:0]       k_inc, k_dec, k_gap;
  logic [CW-1:0]       src_c, src_p1, rc_p1, r_dec;
  logic                bad;

  assign k_inc  = k + 1'b1;
  assign k_dec  = k - 1'b1;
  assign k_gap  = k - 1'b1 - gap;
  assign src_c  = CW'(src);
  assign src_p1 = src_c + 1'b1;
  assign rc_p1  = row_count + 1'b1;
  assign r_dec  = r - 1'b1;
  assign bad    = (32'(request.source_vertex) >= MAX_VERTICES) ||
                  ((request.req_type != REQ_DEL_VERT) &&
                   (32'(request.target_vertex) >= MAX_VERTICES));

  // row start entry zero is always zero and is never stored
  assign rs_q = rs_zero ? '0 : rs_rdata;
  assign busy = (state != S_IDLE);

  // memories
  always_ff @(posedge clk) begin
    if (nl_we) nl_mem[nl_waddr] <= nl_wdata;
    nl_rdata <= nl_mem[nl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
    rs_rdata <= rs_mem[rs_raddr];
    rs_zero  <= (rs_raddr == '0);
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      row_count <= '0;
      done      <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      row_count <= row_count_next;
      done      <= done_next;
      pend      <= pend_next;
    end
    rtype   <= rtype_next;
    src     <= src_next;
    dst     <= dst_next;
    found   <= found_next;
    status  <= status_next;
    removed <= removed_next;
    k       <= k_next;
    e       <= e_next;
    b       <= b_next;
    pos     <= pos_next;
    gap     <= gap_next;
    r       <= r_next;
    inc     <= inc_next;
    result  <= result_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    rtype_next     = rtype;
    src_next       = src;
    dst_next       = dst;
    found_next     = found;
    status_next    = status;
    removed_next   = removed;
    total_next     = total;
    row_count_next = row_count;
    k_next         = k;
    e_next         = e;
    b_next         = b;
    pos_next       = pos;
    gap_next       = gap;
    r_next         = r;
    pend_next      = pend;
    inc_next       = inc;
    done_next      = 1'b0;
    result_next    = result;
    nl_raddr       = k[AW-1:0];
    nl_waddr       = k[AW-1:0];
    nl_wdata       = nl_rdata;
    nl_we          = 1'b0;
    rs_raddr       = r[RW-1:0];
    rs_waddr       = r[RW-1:0];
    rs_wdata       = rs_q;
    rs_we          = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          rtype_next   = request.req_type;
          src_next     = request.source_vertex;
          dst_next     = request.target_vertex;
          found_next   = 1'b0;
          removed_next = '0;
          status_next  = bad ? ST_RANGE : ST_OK;
          state_next   = bad ? S_DONE : S_LOOKUP;
        end
      end

      // find the source row bounds
      S_LOOKUP: begin
        if (rtype == REQ_DEL_VERT) begin
          r_next     = '0;
          k_next     = '0;
          gap_next   = '0;
          state_next = S_RV_ROW;
        end else if (src_c >= row_count) begin
          pos_next   = total;
          state_next = S_DECIDE;
        end else begin
          rs_raddr   = src_c[RW-1:0];
          state_next = S_RS_B;
        end
      end

      S_RS_B: begin
        b_next     = rs_q;
        rs_raddr   = src_p1[RW-1:0];
        state_next = S_RS_E;
      end

      S_RS_E: begin
        e_next     = rs_q;
        k_next     = b;
        pend_next  = 1'b0;
        state_next = S_SCAN;
      end

      // linear scan for the first entry not below the target
      S_SCAN: begin
        if (pend && (nl_rdata >= dst)) begin
          pos_next   = k_dec;
          found_next = (nl_rdata == dst);
          pend_next  = 1'b0;
          state_next = S_DECIDE;
        end else if (k < e) begin
          nl_raddr  = k[AW-1:0];
          k_next    = k_inc;
          pend_next = 1'b1;
        end else begin
          pos_next   = e;
          pend_next  = 1'b0;
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (rtype)
          REQ_ADD_EDGE: begin
            if (!found && (total >= EW'(MAX_EDGES))) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              state_next = S_APPEND;
            end
          end
          REQ_DEL_EDGE: begin
            if (found) begin
              removed_next = EW'(1);
              k_next       = pos;
              pend_next    = 1'b0;
              state_next   = S_SHDN;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end

      // append empty rows up to the source
      S_APPEND: begin
        if (row_count < src_p1) begin
          rs_we          = 1'b1;
          rs_waddr       = rc_p1[RW-1:0];
          rs_wdata       = total;
          row_count_next = rc_p1;
        end else if (found) begin
          state_next = S_DONE;
        end else begin
          k_next     = total;
          pend_next  = 1'b0;
          state_next = S_SHUP;
        end
      end

      // shift entries up by one, top first
      S_SHUP: begin
        if (pend) begin
          nl_we    = 1'b1;
          nl_waddr = k_inc[AW-1:0];
        end
        if (k > pos) begin
          nl_raddr  = k_dec[AW-1:0];
          k_next    = k_dec;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = S_INS;
        end
      end

      S_INS: begin
        nl_we      = 1'b1;
        nl_waddr   = pos[AW-1:0];
        nl_wdata   = dst;
        total_next = total + 1'b1;
        r_next     = src_p1;
        inc_next   = 1'b1;
        pend_next  = 1'b0;
        state_next = S_ADJ;
      end

      // close the gap, bottom first
      S_SHDN: begin
        if (pend) begin
          nl_we    = 1'b1;
          nl_waddr = k_dec[AW-1:0];
        end
        if (k_inc < total) begin
          nl_raddr  = k_inc[AW-1:0];
          k_next    = k_inc;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          total_next = total - 1'b1;
          r_next     = src_p1;
          inc_next   = 1'b0;
          state_next = S_ADJ;
        end
      end

      // bump or lower the starts of the later rows
      S_ADJ: begin
        if (pend) begin
          rs_we    = 1'b1;
          rs_waddr = r_dec[RW-1:0];
          rs_wdata = inc ? rs_q + 1'b1 : rs_q - 1'b1;
        end
        if (r <= row_count) begin
          rs_raddr  = r[RW-1:0];
          r_next    = r + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = S_DONE;
        end
      end

      // vertex removal: walk every row, compacting as we go
      S_RV_ROW: begin
        if (r == row_count) begin
          if (row_count != '0) begin
            rs_we    = 1'b1;
            rs_waddr = row_count[RW-1:0];
            rs_wdata = total - gap;
          end
          total_next   = total - gap;
          removed_next = gap;
          state_next   = S_DONE;
        end else begin
          rs_raddr   = r[RW-1:0] + 1'b1;
          state_next = S_RV_E;
        end
      end

      S_RV_E: begin
        e_next = rs_q;
        if (r != '0) begin
          rs_we    = 1'b1;
          rs_waddr = r[RW-1:0];
          rs_wdata = k - gap;
        end
        if (r == src_c) begin
          gap_next   = gap + (rs_q - k);
          k_next     = rs_q;
          r_next     = r + 1'b1;
          state_next = S_RV_ROW;
        end else begin
          pend_next  = 1'b0;
          state_next = S_RV_SCAN;
        end
      end

      S_RV_SCAN: begin
        if (pend) begin
          if (nl_rdata == src) begin
            gap_next = gap + 1'b1;
          end else begin
            nl_we    = 1'b1;
            nl_waddr = k_gap[AW-1:0];
          end
        end
        if (k < e) begin
          nl_raddr  = k[AW-1:0];
          k_next    = k_inc;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          r_next     = r + 1'b1;
          state_next = S_RV_ROW;
        end
      end

      S_DONE: begin
        result_next.edge_found    = found;
        result_next.status        = status;
        result_next.removed_count = CNT_W'(removed);
        result_next.edge_total    = CNT_W'(total);
        done_next                 = 1'b1;
        state_next                = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // checks
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_bounds, clk, rst, 1'b1,
               (total <= EW'(MAX_EDGES)) && (row_count <= CW'(MAX_VERTICES)))
  `ASSERT_IMPL(a_flag_clean, clk, rst, done && (result.status != ST_OK),
               !result.edge_found && (result.removed_count == '0))

endmodule

// File: bench/csr_adj_checker.sv
// Watches the request and result channels, models the graph and compares results
module csr_adj_checker
  import csr_adj_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  req_t    request,
  input  logic    done,
  input  result_t result,
  output int      fail_count,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // graph model in CSR form
  logic [CNT_W-1:0]    row_base [MAX_VERTICES+1];
  logic [VERTEX_W-1:0] dest_list [MAX_EDGES];
  int                  rows_used;
  result_t             expected_results [$];

  function automatic int stored_edges();
    return int'(row_base[rows_used]);
  endfunction

  // sorted position of dst in row src; returns whether it is there
  function automatic bit locate(int src, int dst, output int pos);
    int lo;
    int hi;
    pos = 0;
    if (src >= rows_used) return 1'b0;
    lo = int'(row_base[src]);
    hi = int'(row_base[src+1]);
    while (lo < hi && int'(dest_list[lo]) < dst) lo++;
    pos = lo;
    return lo < hi && int'(dest_list[lo]) == dst;
  endfunction

  function automatic void grow_rows(int src);
    while (rows_used < src + 1) begin
      row_base[rows_used+1] = row_base[rows_used];
      rows_used++;
    end
  endfunction

  function automatic int drop_vertex(int vtx);
    int gap;
    int b;
    int e;
    gap = 0;
    for (int v = 0; v < rows_used; v++) begin
      b = int'(row_base[v]);
      e = int'(row_base[v+1]);
      row_base[v] = CNT_W'(b - gap);
      if (v != vtx) begin
        for (int k = b; k < e; k++) begin
          dest_list[k-gap] = dest_list[k];
          if (int'(dest_list[k]) == vtx) gap++;
        end
      end else begin
        gap += e - b;
      end
    end
    row_base[rows_used] = CNT_W'(int'(row_base[rows_used]) - gap);
    return gap;
  endfunction

  function automatic result_t apply_request(req_t r);
    result_t res;
    int src;
    int dst;
    int pos;
    int total;
    src = int'(r.source_vertex);
    dst = int'(r.target_vertex);
    res = '0;
    res.status = ST_OK;
    if (src >= MAX_VERTICES || (r.req_type != REQ_DEL_VERT && dst >= MAX_VERTICES)) begin
      res.status = ST_RANGE;
    end else begin
      case (r.req_type)
        REQ_ADD_EDGE: begin
          if (locate(src, dst, pos)) begin
            res.edge_found = 1'b1;
            grow_rows(src);
          end else if (stored_edges() >= MAX_EDGES) begin
            res.status = ST_FULL;
          end else begin
            grow_rows(src);
            void'(locate(src, dst, pos));
            total = stored_edges();
            for (int k = total; k > pos; k--) dest_list[k] = dest_list[k-1];
            dest_list[pos] = VERTEX_W'(dst);
            for (int q = src + 1; q <= rows_used; q++) row_base[q]++;
          end
        end
        REQ_DEL_EDGE: begin
          if (locate(src, dst, pos)) begin
            total = stored_edges();
            res.edge_found = 1'b1;
            res.removed_count = CNT_W'(1);
            for (int k = pos; k + 1 < total; k++) dest_list[k] = dest_list[k+1];
            for (int q = src + 1; q <= rows_used; q++) row_base[q]--;
          end
        end
        REQ_DEL_VERT: res.removed_count = CNT_W'(drop_vertex(src));
        default:      res.edge_found = locate(src, dst, pos);
      endcase
    end
    res.edge_total = CNT_W'(stored_edges());
    return res;
  endfunction

  assign pending = expected_results.size();

  // results first (oldest request), then a request taken at the same edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rows_used = 0;
      row_base[0] = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", result);
        end else begin
          want = expected_results.pop_front();
          if (result.edge_found !== want.edge_found || result.status !== want.status ||
              result.removed_count !== want.removed_count ||
              result.edge_total !== want.edge_total) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p got %p", want, result);
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_request(request));
    end
  end
endmodule

// File: bench/tb_top.sv
module tb_top;
  import csr_adj_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  logic    done;
  req_t    request = '0;
  result_t result;
  int      fail_count;
  int      pending;
  int      cycles = 0;

  always #5 clk = ~clk;

  csr_adjacency_edge_table DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  csr_adj_checker scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL csr_adjacency_edge_table");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // issue one request, keep start high if no gap follows
  task automatic issue(req_type_t kind, int src, int dst, int gap);
    @(negedge clk);
    start <= 1'b1;
    request <= '{req_type: kind, source_vertex: VERTEX_W'(src), target_vertex: VERTEX_W'(dst)};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_vertex();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 12);
    return $urandom_range(0, 255);
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty graph, extremes, shifting inserts, self loop
    issue(REQ_QUERY, 0, 0, 1);
    issue(REQ_DEL_EDGE, 7, 3, 0);
    issue(REQ_DEL_VERT, 9, 0, 2);
    issue(REQ_ADD_EDGE, 0, 0, 0);
    issue(REQ_ADD_EDGE, 0, 255, 0);
    issue(REQ_ADD_EDGE, 255, 0, 3);
    issue(REQ_ADD_EDGE, 255, 255, 0);
    issue(REQ_ADD_EDGE, 0, 255, 0);
    issue(REQ_ADD_EDGE, 10, 9, 1);
    issue(REQ_ADD_EDGE, 10, 1, 0);
    issue(REQ_ADD_EDGE, 10, 5, 0);
    issue(REQ_ADD_EDGE, 5, 5, 0);
    issue(REQ_ADD_EDGE, 5, 3, 0);
    issue(REQ_ADD_EDGE, 3, 5, 0);
    issue(REQ_ADD_EDGE, 10, 5, 2);
    issue(REQ_QUERY, 10, 5, 0);
    issue(REQ_QUERY, 10, 6, 0);
    issue(REQ_QUERY, 200, 6, 0);
    issue(REQ_DEL_VERT, 5, 170, 0);
    issue(REQ_DEL_EDGE, 10, 5, 0);
    issue(REQ_DEL_EDGE, 10, 5, 0);
    issue(REQ_DEL_VERT, 0, 85, 1);
    issue(REQ_DEL_VERT, 255, 0, 0);
    issue(REQ_QUERY, 255, 255, 0);

    // random mix on a small vertex set, some full range
    for (int i = 0; i < 110; i++)
      issue(req_type_t'($urandom_range(0, 3)), pick_vertex(), pick_vertex(), pick_gap());

    // late requests on rows far apart
    issue(REQ_ADD_EDGE, 20, 77, 0);
    issue(REQ_QUERY, 250, 100, 0);
    issue(REQ_DEL_VERT, 100, 0, 0);
    issue(REQ_ADD_EDGE, 20, 77, 0);
    issue(REQ_DEL_EDGE, 240, 0, 1);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS csr_adjacency_edge_table");
    end else begin
      $display("FAIL csr_adjacency_edge_table");
    end
    $finish;
  end
endmodule

// File: csr_adjacency_edge_table.f
+incdir+design
design/csr_adj_pkg.sv
design/csr_adjacency_edge_table.sv
bench/csr_adj_checker.sv
bench/tb_top.sv
